@@ rtl/core/ims_pkg.sv @@
// ----------------------------------------------------------------------------
// ims_pkg
// Shared types and constants of the integer merge sorter.
// ----------------------------------------------------------------------------
package ims_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    store;
    logic                    last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MERGE,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } back_state_e;

endpackage

@@ rtl/core/ims_front.sv @@
// ----------------------------------------------------------------------------
// ims_front
// Accepts input items, counts the array and marks each item to be stored or
// dropped before it enters the command queue.
// ----------------------------------------------------------------------------
module ims_front import ims_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_i,
  input  logic                    full_i,
  output logic                    push_o,
  output cmd_t                    cmd_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          store;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign store      = (cnt_q < CW'(DEPTH));

  assign cmd_o.value = value_i;
  assign cmd_o.store = store;
  assign cmd_o.last  = last_i;
  assign push_o      = accept && (store || last_i);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (store) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/core/ims_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ims_cmd_fifo
// Short command queue that decouples the front from the sort engine.
// ----------------------------------------------------------------------------
module ims_cmd_fifo import ims_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t cmd_o
);

  cmd_t           entry_q [QDepth];
  logic [QAw-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAw-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAw:0]   fill_q, fill_d;
  logic           do_push;
  logic           do_pop;

  assign full_o      = (fill_q == (QAw + 1)'(QDepth));
  assign pop_valid_o = (fill_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QAw'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QAw'(1) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + (QAw + 1)'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - (QAw + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

@@ rtl/core/ims_back.sv @@
// ----------------------------------------------------------------------------
// ims_back
// Sort engine: loads elements, runs bottom-up merge passes between two
// buffers and emits the sorted array.
// ----------------------------------------------------------------------------
module ims_back import ims_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  output logic                    cmd_ready_o,
  input  cmd_t                    cmd_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = CW + 2;

  function automatic logic [IW-1:0] idx_min(input logic [IW-1:0] a, input logic [IW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  logic signed [DataW-1:0] mem_a [DEPTH];
  logic signed [DataW-1:0] mem_b [DEPTH];
  logic signed [DataW-1:0] rd0_q, rd1_q;

  back_state_e   state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] e_q, e_d;
  logic [IW-1:0] width_q, width_d;
  logic [IW-1:0] i_q, i_d, mid_q, mid_d, j_q, j_d, hi_q, hi_d, k_q, k_d;
  logic          src_sel_q, src_sel_d;

  logic          we, wsel;
  logic [AW-1:0] waddr;
  logic signed [DataW-1:0] wdata;
  logic          ren;
  logic [AW-1:0] ra0, ra1;

  logic [CW-1:0] n_new;
  logic [CW-1:0] e_inc;
  logic [IW-1:0] n_ext;
  logic [IW-1:0] width2;
  logic [IW-1:0] base, step;
  logic          left_ok, right_ok, take_left;

  assign n_new          = cnt_q + CW'(cmd_i.store);
  assign e_inc          = e_q + CW'(1);
  assign n_ext          = IW'(n_q);
  assign width2         = width_q << 1;
  assign left_ok        = (i_q < mid_q);
  assign right_ok       = (j_q < hi_q);
  assign take_left      = left_ok && (!right_ok || (rd0_q <= rd1_q));
  assign sorted_value_o = rd0_q;
  assign last_res_o     = (e_inc == n_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    e_d         = e_q;
    width_d     = width_q;
    i_d         = i_q;
    mid_d       = mid_q;
    j_d         = j_q;
    hi_d        = hi_q;
    k_d         = k_q;
    src_sel_d   = src_sel_q;
    we          = 1'b0;
    wsel        = 1'b0;
    waddr       = cnt_q[AW-1:0];
    wdata       = cmd_i.value;
    ren         = 1'b0;
    ra0         = i_q[AW-1:0];
    ra1         = j_q[AW-1:0];
    cmd_ready_o = 1'b0;
    out_valid_o = 1'b0;
    base        = hi_q;
    step        = width_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          we = cmd_i.store;
          if (cmd_i.last) begin
            cnt_d     = '0;
            n_d       = n_new;
            src_sel_d = 1'b0;
            if (n_new >= CW'(2)) begin
              width_d = IW'(1);
              i_d     = '0;
              mid_d   = IW'(1);
              j_d     = IW'(1);
              hi_d    = IW'(2);
              k_d     = '0;
              state_d = ST_READ;
            end else begin
              e_d     = '0;
              state_d = ST_EMIT_RD;
            end
          end else begin
            cnt_d = n_new;
          end
        end
      end
      ST_READ: begin
        ren     = 1'b1;
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        we    = 1'b1;
        wsel  = !src_sel_q;
        waddr = k_q[AW-1:0];
        wdata = take_left ? rd0_q : rd1_q;
        k_d   = k_q + IW'(1);
        if (take_left) begin
          i_d = i_q + IW'(1);
        end else begin
          j_d = j_q + IW'(1);
        end
        state_d = ST_READ;
        if (k_q + IW'(1) == hi_q) begin
          if (hi_q >= n_ext) begin
            src_sel_d = !src_sel_q;
            base      = '0;
            step      = width2;
            width_d   = width2;
            if (width2 >= n_ext) begin
              e_d     = '0;
              state_d = ST_EMIT_RD;
            end
          end
          i_d   = base;
          k_d   = base;
          mid_d = idx_min(base + step, n_ext);
          j_d   = idx_min(base + step, n_ext);
          hi_d  = idx_min(base + (step << 1), n_ext);
        end
      end
      ST_EMIT_RD: begin
        ren     = 1'b1;
        ra0     = e_q[AW-1:0];
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          e_d     = e_inc;
          state_d = (e_inc == n_q) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we && !wsel) begin
      mem_a[waddr] <= wdata;
    end
    if (we && wsel) begin
      mem_b[waddr] <= wdata;
    end
    if (ren) begin
      rd0_q <= src_sel_q ? mem_b[ra0] : mem_a[ra0];
      rd1_q <= src_sel_q ? mem_b[ra1] : mem_a[ra1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      n_q       <= '0;
      e_q       <= '0;
      width_q   <= '0;
      i_q       <= '0;
      mid_q     <= '0;
      j_q       <= '0;
      hi_q      <= '0;
      k_q       <= '0;
      src_sel_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      n_q       <= n_d;
      e_q       <= e_d;
      width_q   <= width_d;
      i_q       <= i_d;
      mid_q     <= mid_d;
      j_q       <= j_d;
      hi_q      <= hi_d;
      k_q       <= k_d;
      src_sel_q <= src_sel_d;
    end
  end

endmodule

@@ rtl/core/integer_merge_sorter.sv @@
// ----------------------------------------------------------------------------
// integer_merge_sorter
// Stable ascending merge sort of signed 32-bit integers, one array at a time.
// ----------------------------------------------------------------------------
// The input channel takes one element per item; last_i marks the end of the
// array. Up to DEPTH elements are kept, later ones are dropped until the last
// item. Items pass through a two-entry queue, so loading runs at one item per
// cycle while the sort engine is free.
// On the last item the engine runs ceil(log2 n) merge passes over n elements
// with a single merge unit that reads both run heads from one buffer and
// writes the other; each element of a pass is read (ST_READ) and then merged
// and written (ST_MERGE). It then emits the n results, each read (ST_EMIT_RD)
// and then offered (ST_EMIT_OUT), the final one with last_res_o high. The
// engine takes no new item until the last result has been taken.
// A stalled receiver holds the current result and its valid; the engine waits
// and the queue fills, after which in_ready_o drops. Reset empties the queue,
// clears the element counts and returns the engine to idle; buffer contents
// are not cleared.
// ----------------------------------------------------------------------------
module integer_merge_sorter import ims_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] sorted_value_o,
  output logic                    last_res_o
);

  logic push;
  logic full;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  ims_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .last_i     (last_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ims_cmd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .cmd_i       (push_cmd),
    .full_o      (full),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .cmd_o       (pop_cmd)
  );

  ims_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (pop_valid),
    .cmd_ready_o    (pop_ready),
    .cmd_i          (pop_cmd),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sorted_value_o (sorted_value_o),
    .last_res_o     (last_res_o)
  );

endmodule
